// ===== sv/rtcm_pkg.sv =====
`default_nettype none

package rtcm_pkg;

   // Frame layout constants.
   localparam logic [7:0]  PREAMBLE_BYTE  = 8'hD3;
   localparam logic [24:0] CRC24Q_POLY    = 25'h1864CFB;
   localparam logic [9:0]  MAX_LEN_RESET  = 10'd1023;

   localparam int DATA_W   = 8;
   localparam int LEN_W    = 10;
   localparam int ID_W     = 12;
   localparam int CRC_W    = 24;

   // Receiver phase.
   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_PAYLOAD,
      PH_CRC
   } phase_type;

   // One byte of CRC-24Q, most significant bit first, no reflection.
   function automatic logic [CRC_W-1:0] crc24q_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [DATA_W-1:0] data);
      logic [CRC_W:0] acc;
      acc = {1'b0, crc ^ {data, 16'h0000}};
      for (int k = 0; k < DATA_W; k++) begin
         acc = {acc[CRC_W-1:0], 1'b0};
         if (acc[CRC_W]) begin
            acc = acc ^ CRC24Q_POLY;
         end
      end
      return acc[CRC_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/rtcm_channels.sv =====
`default_nettype none

// Byte stream into the receiver.
interface rtcm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// One result per completed frame.
interface rtcm_rsp_if;
   logic        valid;
   logic        ready;
   logic        crc_ok;
   logic [11:0] message_id;
   logic [9:0]  payload_length;

   modport source (output valid, output crc_ok, output message_id, output payload_length,
                   input ready);
   modport sink   (input valid, input crc_ok, input message_id, input payload_length,
                   output ready);
endinterface

// Write port of the maximum payload length register.
interface rtcm_csr_if;
   logic       valid;
   logic       ready;
   logic [9:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/rtcm3_frame_receiver.sv =====
// RTCM 3 frame receiver with CRC-24Q check.
// req_chan carries one received byte per transfer. The block hunts for the
// 0xD3 preamble, reads the two header bytes with the 10-bit payload length,
// counts the payload and gathers the three CRC bytes. When the last CRC byte
// is taken, one transfer on rsp_chan gives the CRC verdict, the 12-bit
// message id and the payload length. Frames with a length of zero or above
// the configured maximum are dropped without a result.
// csr_chan writes the maximum payload length; it is always ready and should
// only be written while no frame is in progress.
// Throughput: one byte per cycle while req_chan.ready is high. Each byte is
// processed in the cycle it is transferred; the result appears in the output
// register in the cycle after the last CRC byte. req_chan.ready drops only
// while a result waits in that register and rsp_chan.ready is low, so a
// stalled receiver holds the byte stream back by exactly that one register.
// Reset (synchronous, active high) returns the block to preamble hunting,
// empties the output register and sets the maximum length to 1023.
`default_nettype none

module rtcm3_frame_receiver (
   input  wire              clock,
   input  wire              reset,
   rtcm_req_if.sink         req_chan,
   rtcm_rsp_if.source       rsp_chan,
   rtcm_csr_if.sink         csr_chan
);

   localparam int LEN_W = rtcm_pkg::LEN_W;
   localparam int ID_W  = rtcm_pkg::ID_W;
   localparam int CRC_W = rtcm_pkg::CRC_W;

   rtcm_pkg::phase_type phase_ff, phase_in;
   logic             header_cnt_ff, header_cnt_in;
   logic [1:0]       first_len_ff, first_len_in;
   logic [LEN_W-1:0] frame_len_ff, frame_len_in;
   logic [LEN_W-1:0] payload_cnt_ff, payload_cnt_in;
   logic [CRC_W-1:0] crc_run_ff, crc_run_in;
   logic [CRC_W-1:0] crc_rcv_ff, crc_rcv_in;
   logic [1:0]       crc_cnt_ff, crc_cnt_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [LEN_W-1:0] max_len_ff, max_len_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_crc_ok_ff, rsp_crc_ok_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;

   logic             req_fire;
   logic             rsp_load;
   logic [7:0]       data;
   logic [LEN_W-1:0] header_len;
   logic [LEN_W-1:0] payload_cnt_inc;
   logic [CRC_W-1:0] crc_next;
   logic [CRC_W-1:0] crc_rcv_next;

   // Handshakes: a byte is taken whenever the output register can take a result.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.crc_ok         = rsp_crc_ok_ff;
   assign rsp_chan.message_id     = rsp_id_ff;
   assign rsp_chan.payload_length = rsp_len_ff;

   assign data            = req_chan.data_byte;
   assign header_len      = {first_len_ff, data};
   assign payload_cnt_inc = payload_cnt_ff + 1'b1;
   assign crc_next        = rtcm_pkg::crc24q_byte(crc_run_ff, data);
   assign crc_rcv_next    = {crc_rcv_ff[CRC_W-9:0], data};

   // Configuration register.
   always_comb begin
      max_len_in = max_len_ff;
      if (csr_chan.valid) begin
         max_len_in = csr_chan.data;
      end
   end

   // Frame state machine: next state and result load.
   always_comb begin
      phase_in       = phase_ff;
      header_cnt_in  = header_cnt_ff;
      first_len_in   = first_len_ff;
      frame_len_in   = frame_len_ff;
      payload_cnt_in = payload_cnt_ff;
      crc_run_in     = crc_run_ff;
      crc_rcv_in     = crc_rcv_ff;
      crc_cnt_in     = crc_cnt_ff;
      id_in          = id_ff;
      rsp_load       = 1'b0;
      rsp_crc_ok_in  = rsp_crc_ok_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_len_in     = rsp_len_ff;

      if (req_fire) begin
         unique case (phase_ff)
            rtcm_pkg::PH_HUNT: begin
               if (data == rtcm_pkg::PREAMBLE_BYTE) begin
                  phase_in      = rtcm_pkg::PH_HEADER;
                  header_cnt_in = 1'b0;
                  crc_run_in    = rtcm_pkg::crc24q_byte('0, data);
               end
            end
            rtcm_pkg::PH_HEADER: begin
               crc_run_in = crc_next;
               if (!header_cnt_ff) begin
                  first_len_in  = data[1:0];
                  header_cnt_in = 1'b1;
               end else if (header_len == '0 || header_len > max_len_ff) begin
                  // Bad length: drop the frame and look at this byte as a preamble.
                  phase_in = rtcm_pkg::PH_HUNT;
                  if (data == rtcm_pkg::PREAMBLE_BYTE) begin
                     phase_in      = rtcm_pkg::PH_HEADER;
                     header_cnt_in = 1'b0;
                     crc_run_in    = rtcm_pkg::crc24q_byte('0, data);
                  end
               end else begin
                  frame_len_in   = header_len;
                  payload_cnt_in = '0;
                  phase_in       = rtcm_pkg::PH_PAYLOAD;
               end
            end
            rtcm_pkg::PH_PAYLOAD: begin
               crc_run_in = crc_next;
               // The message id is the top 12 bits of the first two payload bytes.
               if (payload_cnt_ff == '0) begin
                  id_in = {data, 4'h0};
               end else if (payload_cnt_ff == LEN_W'(1)) begin
                  id_in = {id_ff[ID_W-1:4], data[7:4]};
               end
               payload_cnt_in = payload_cnt_inc;
               if (payload_cnt_inc >= frame_len_ff) begin
                  phase_in   = rtcm_pkg::PH_CRC;
                  crc_cnt_in = '0;
               end
            end
            rtcm_pkg::PH_CRC: begin
               crc_rcv_in = crc_rcv_next;
               crc_cnt_in = crc_cnt_ff + 1'b1;
               if (crc_cnt_ff == 2'd2) begin
                  rsp_load      = 1'b1;
                  rsp_crc_ok_in = (crc_rcv_next == crc_run_ff);
                  rsp_id_in     = (frame_len_ff < LEN_W'(2)) ? '0 : id_ff;
                  rsp_len_in    = frame_len_ff;
                  phase_in      = rtcm_pkg::PH_HUNT;
               end
            end
            default: begin
               phase_in = rtcm_pkg::PH_HUNT;
            end
         endcase
      end

      if (!rsp_load) begin
         rsp_crc_ok_in = rsp_crc_ok_ff;
         rsp_id_in     = rsp_id_ff;
         rsp_len_in    = rsp_len_ff;
      end
   end

   // Output register valid: set by a new result, cleared by its transfer.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= rtcm_pkg::PH_HUNT;
         header_cnt_ff  <= 1'b0;
         payload_cnt_ff <= '0;
         crc_cnt_ff     <= '0;
         frame_len_ff   <= '0;
         max_len_ff     <= rtcm_pkg::MAX_LEN_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         header_cnt_ff  <= header_cnt_in;
         payload_cnt_ff <= payload_cnt_in;
         crc_cnt_ff     <= crc_cnt_in;
         frame_len_ff   <= frame_len_in;
         max_len_ff     <= max_len_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      first_len_ff  <= first_len_in;
      crc_run_ff    <= crc_run_in;
      crc_rcv_ff    <= crc_rcv_in;
      id_ff         <= id_in;
      rsp_crc_ok_ff <= rsp_crc_ok_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_len_ff    <= rsp_len_in;
   end

   // The last CRC byte always produces a result in the next cycle.
   a_result_after_crc: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == rtcm_pkg::PH_CRC && crc_cnt_ff == 2'd2) |=> rsp_valid_ff)
      else $error("missing result after last CRC byte");

   // A frame in payload phase has a nonzero length and has not yet been fully read.
   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rtcm_pkg::PH_PAYLOAD) |-> (frame_len_ff != '0 &&
                                              payload_cnt_ff < frame_len_ff))
      else $error("payload count out of range");

   // The byte stream is held back only by a waiting result.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_valid_ff && !rsp_chan.ready))
      else $error("input stalled without a waiting result");

   // A new result is loaded only when the previous one is gone or leaving.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result overwritten");

endmodule

`default_nettype wire
